### sv/mm_pkg.sv
// Shared types, constants and helper functions of the matrix multiply block.
package mm_pkg;

	localparam int MAX_DIM    = 8;
	localparam int VALUE_BITS = 16;
	localparam int PROD_W     = 35;
	localparam int DIM_W      = 4;
	localparam int POS_W      = 3;
	localparam int FUNC_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int AW         = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_A_COLUMNS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_B_COLUMNS = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
		logic             err;
	} token_t;

	typedef struct packed {
		logic                   a_we;
		logic                   b_we;
		logic [POS_W-1:0]       row;
		logic [POS_W-1:0]       col;
		logic [VALUE_BITS-1:0]  value;
	} entry_wr_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] idx;
		logic [DIM_W-1:0]     data;
	} cfg_wr_t;

	typedef struct packed {
		logic             idle;
		logic [DIM_W-1:0] ac;
	} seq_stat_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		return (r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r;
	endfunction

endpackage

### sv/mm_if.sv
// Handshake interfaces for the entry requests, the product results and configuration.
interface mm_item_if import mm_pkg::*; ;
	logic                          valid;
	logic                          ready;
	logic [FUNC_W-1:0]             func;
	logic [POS_W-1:0]              entry_row;
	logic [POS_W-1:0]              entry_column;
	logic signed [VALUE_BITS-1:0]  entry_value;

	modport source (output valid, func, entry_row, entry_column, entry_value, input ready);
	modport sink (input valid, func, entry_row, entry_column, entry_value, output ready);
endinterface

interface mm_result_if import mm_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic [POS_W-1:0]          product_row;
	logic [POS_W-1:0]          product_column;
	logic signed [PROD_W-1:0]  product_value;
	logic                      last_entry;
	logic                      size_error;

	modport source (output valid, product_row, product_column, product_value, last_entry,
		size_error, input ready);
	modport sink (input valid, product_row, product_column, product_value, last_entry,
		size_error, output ready);
endinterface

interface mm_cfg_if import mm_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/matrix_multiply.sv
// Top level of the matrix multiply block: entry decode, cell chain and result register.
// A compute request's positions pass from the sequencer register through the stages
// (tok_s1, tok_s2) of each cell and the result register; results then follow one per cycle
// while the receiver is ready, a_rows*b_columns results (one error result on a size mismatch).
// The next request is accepted once the sequencer is idle and the cell chain has drained.
// Reset clears control state and sets all dimensions to 8; the stores are not cleared.
module matrix_multiply import mm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	mm_item_if.sink      item,
	mm_result_if.source  result,
	mm_cfg_if.sink       cfg
);

	token_t                    tok_c [MAX_DIM+1];
	logic signed [PROD_W-1:0]  sum_c [MAX_DIM+1];
	logic [MAX_DIM-1:0]        cell_busy;
	seq_stat_t                 stat;
	cfg_wr_t                   cfg_wr;
	entry_wr_t                 wr;
	logic                      adv, accept, start, in_range;

	logic                      out_valid_q;
	logic [POS_W-1:0]          out_row_q, out_col_q;
	logic signed [PROD_W-1:0]  out_value_q;
	logic                      out_last_q, out_err_q;

	assign adv         = !out_valid_q || result.ready;
	assign item.ready  = stat.idle && (cell_busy == '0);
	assign accept      = item.valid && item.ready;
	assign start       = accept && (item.func == FUNC_COMPUTE);
	assign in_range    = ({1'b0, item.entry_row} < DIM_W'(MAX_DIM))
		&& ({1'b0, item.entry_column} < DIM_W'(MAX_DIM));

	assign cfg.ready   = 1'b1;
	assign cfg_wr.we   = cfg.valid;
	assign cfg_wr.idx  = cfg.index;
	assign cfg_wr.data = cfg.data;

	assign wr.a_we  = accept && in_range && (item.func == FUNC_WRITE_A);
	assign wr.b_we  = accept && in_range && (item.func == FUNC_WRITE_B);
	assign wr.row   = item.entry_row;
	assign wr.col   = item.entry_column;
	assign wr.value = item.entry_value;

	mm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.start  (start),
		.adv    (adv),
		.tok    (tok_c[0]),
		.stat   (stat)
	);

	assign sum_c[0] = '0;

	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		mm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.k_idx   (DIM_W'(g)),
			.ac      (stat.ac),
			.adv     (adv),
			.wr      (wr),
			.tok_in  (tok_c[g]),
			.sum_in  (sum_c[g]),
			.tok_out (tok_c[g+1]),
			.sum_out (sum_c[g+1]),
			.busy    (cell_busy[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tok_c[MAX_DIM].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok_c[MAX_DIM].valid) begin
			out_row_q   <= tok_c[MAX_DIM].row;
			out_col_q   <= tok_c[MAX_DIM].col;
			out_value_q <= sum_c[MAX_DIM];
			out_last_q  <= tok_c[MAX_DIM].last;
			out_err_q   <= tok_c[MAX_DIM].err;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.product_row    = out_row_q;
	assign result.product_column = out_col_q;
	assign result.product_value  = out_value_q;
	assign result.last_entry     = out_last_q;
	assign result.size_error     = out_err_q;

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> out_last_q && out_value_q == '0
			&& out_row_q == '0 && out_col_q == '0)
		else $error("error result carries a position or value");

	a_no_write_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.a_we || wr.b_we) |-> cell_busy == '0 && !tok_c[0].valid)
		else $error("entry written while products are in flight");

endmodule

### sv/mm_cell.sv
// One cell of the multiply chain: holds one column of A and one row of B, adds its term.
module mm_cell import mm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [DIM_W-1:0]          k_idx,
	input  logic [DIM_W-1:0]          ac,
	input  logic                      adv,
	input  entry_wr_t                 wr,
	input  token_t                    tok_in,
	input  logic signed [PROD_W-1:0]  sum_in,
	output token_t                    tok_out,
	output logic signed [PROD_W-1:0]  sum_out,
	output logic                      busy
);

	logic signed [VALUE_BITS-1:0] a_col_q [MAX_DIM];
	logic signed [VALUE_BITS-1:0] b_row_q [MAX_DIM];

	token_t                          tok_s1, tok_s2;
	logic signed [PROD_W-1:0]        prod_s1, sum_s1, sum_s2;
	logic signed [PROD_W-1:0]        prod_d;
	logic signed [2*VALUE_BITS-1:0]  mul_d;
	logic                            active;

	assign active = (k_idx < ac);

	always_comb begin
		prod_d = '0;
		mul_d  = a_col_q[tok_in.row[AW-1:0]] * b_row_q[tok_in.col[AW-1:0]];
		if (tok_in.valid && !tok_in.err && active) begin
			prod_d = PROD_W'(mul_d);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.a_we && ({1'b0, wr.col} == {1'b0, k_idx[POS_W-1:0]})
				&& (k_idx[DIM_W-1] == 1'b0)) begin
			a_col_q[wr.row[AW-1:0]] <= wr.value;
		end
		if (wr.b_we && ({1'b0, wr.row} == {1'b0, k_idx[POS_W-1:0]})
				&& (k_idx[DIM_W-1] == 1'b0)) begin
			b_row_q[wr.col[AW-1:0]] <= wr.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else if (adv) begin
			tok_s1 <= tok_in;
			tok_s2 <= tok_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_d;
			sum_s1  <= sum_in;
			sum_s2  <= sum_s1 + prod_s1;
		end
	end

	assign tok_out = tok_s2;
	assign sum_out = sum_s2;
	assign busy    = tok_s1.valid | tok_s2.valid;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tok_s1.valid && tok_s1.err |-> prod_s1 == '0)
		else $error("error request picked up a nonzero term");

endmodule

### sv/mm_seq.sv
// Configuration registers and the sequencer that issues one product position per cycle while the chain advances.
module mm_seq import mm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_wr_t   cfg_wr,
	input  logic      start,
	input  logic      adv,
	output token_t    tok,
	output seq_stat_t stat
);

	seq_state_t        state_q, state_d;
	token_t            tok_q, tok_d;
	logic [POS_W-1:0]  i_q, i_d, j_q, j_d;
	logic [DIM_W-1:0]  ar_q, ar_d, bc_q, bc_d, ac_q, ac_d;
	logic [DIM_W-1:0]  a_rows_q, a_columns_q, b_rows_q, b_columns_q;
	logic [DIM_W-1:0]  ar_e, ac_e, br_e, bc_e;
	logic              size_bad, run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= DIM_W'(8);
			a_columns_q <= DIM_W'(8);
			b_rows_q    <= DIM_W'(8);
			b_columns_q <= DIM_W'(8);
		end else if (cfg_wr.we) begin
			case (cfg_wr.idx)
				CFG_A_ROWS:    a_rows_q    <= cfg_wr.data;
				CFG_A_COLUMNS: a_columns_q <= cfg_wr.data;
				CFG_B_ROWS:    b_rows_q    <= cfg_wr.data;
				CFG_B_COLUMNS: b_columns_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	assign ar_e = eff_dim(a_rows_q);
	assign ac_e = eff_dim(a_columns_q);
	assign br_e = eff_dim(b_rows_q);
	assign bc_e = eff_dim(b_columns_q);
	assign size_bad = (ac_e != br_e) || (ar_e == '0) || (ac_e == '0) || (bc_e == '0);
	assign run_last = ({1'b0, i_q} + 4'd1 == ar_q) && ({1'b0, j_q} + 4'd1 == bc_q);

	always_comb begin
		state_d = state_q;
		tok_d   = tok_q;
		i_d     = i_q;
		j_d     = j_q;
		ar_d    = ar_q;
		bc_d    = bc_q;
		ac_d    = ac_q;
		if (start) begin
			ar_d        = ar_e;
			bc_d        = bc_e;
			ac_d        = ac_e;
			tok_d       = '0;
			tok_d.valid = 1'b1;
			if (size_bad) begin
				tok_d.err  = 1'b1;
				tok_d.last = 1'b1;
			end else begin
				tok_d.last = (ar_e == DIM_W'(1)) && (bc_e == DIM_W'(1));
				if (!tok_d.last) begin
					state_d = ST_RUN;
				end
				if (bc_e == DIM_W'(1)) begin
					i_d = POS_W'(1);
					j_d = '0;
				end else begin
					i_d = '0;
					j_d = POS_W'(1);
				end
			end
		end else if (adv) begin
			case (state_q)
				ST_RUN: begin
					tok_d.valid = 1'b1;
					tok_d.row   = i_q;
					tok_d.col   = j_q;
					tok_d.last  = run_last;
					tok_d.err   = 1'b0;
					if (run_last) begin
						state_d = ST_IDLE;
					end
					if ({1'b0, j_q} + 4'd1 == bc_q) begin
						j_d = '0;
						i_d = i_q + POS_W'(1);
					end else begin
						j_d = j_q + POS_W'(1);
					end
				end
				ST_IDLE: tok_d.valid = 1'b0;
				default: state_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tok_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			ar_q    <= '0;
			bc_q    <= '0;
			ac_q    <= '0;
		end else begin
			state_q <= state_d;
			tok_q   <= tok_d;
			i_q     <= i_d;
			j_q     <= j_d;
			ar_q    <= ar_d;
			bc_q    <= bc_d;
			ac_q    <= ac_d;
		end
	end

	assign tok       = tok_q;
	assign stat.idle = (state_q == ST_IDLE) && !tok_q.valid;
	assign stat.ac   = ac_q;

	a_run_issues: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> tok_q.valid && !tok_q.err)
		else $error("sequencer running without a pending position");

	a_run_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == ST_RUN) |-> tok_q.last)
		else $error("run ended without issuing the last position");

endmodule

### verif/tb_matrix_multiply.sv
// Self-checking testbench for the matrix multiply block, with a product scoreboard and random stalls.
module tb_matrix_multiply import mm_pkg::*; ;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 2*MAX_DIM + 8;
	localparam int REQUEST_TARGET = 350;

	typedef struct packed {
		logic [POS_W-1:0]         row;
		logic [POS_W-1:0]         column;
		logic signed [PROD_W-1:0] value;
		logic                     last;
		logic                     size_error;
	} product_t;

	class product_scoreboard;
		logic signed [VALUE_BITS-1:0] a_entries [MAX_DIM*MAX_DIM];
		logic signed [VALUE_BITS-1:0] b_entries [MAX_DIM*MAX_DIM];
		logic [DIM_W-1:0]             dim_reg [4];
		product_t                     pending_products [$];
		int                           mismatches;

		function new();
			foreach (dim_reg[i]) dim_reg[i] = DIM_W'(MAX_DIM);
			foreach (a_entries[i]) begin
				a_entries[i] = '0;
				b_entries[i] = '0;
			end
			mismatches = 0;
		endfunction

		static function int clamp_dim(logic [DIM_W-1:0] raw);
			return (raw > MAX_DIM) ? MAX_DIM : int'(raw);
		endfunction

		function int dim(logic [CFG_IDX_W-1:0] idx);
			return clamp_dim(dim_reg[idx]);
		endfunction

		function bit sizes_agree();
			return dim(CFG_A_COLUMNS) == dim(CFG_B_ROWS) && dim(CFG_A_ROWS) != 0 &&
				dim(CFG_A_COLUMNS) != 0 && dim(CFG_B_COLUMNS) != 0;
		endfunction

		function void note_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
			dim_reg[idx] = data;
		endfunction

		function void note_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] row,
			logic [POS_W-1:0] col, logic signed [VALUE_BITS-1:0] value);
			product_t p;
			longint   acc;
			int       n_rows;
			int       n_inner;
			int       n_cols;
			n_rows  = dim(CFG_A_ROWS);
			n_inner = dim(CFG_A_COLUMNS);
			n_cols  = dim(CFG_B_COLUMNS);
			case (func)
				FUNC_WRITE_A: a_entries[row*MAX_DIM + col] = value;
				FUNC_WRITE_B: b_entries[row*MAX_DIM + col] = value;
				FUNC_COMPUTE: begin
					if (!sizes_agree()) begin
						p = '0;
						p.last = 1'b1;
						p.size_error = 1'b1;
						pending_products.push_back(p);
					end else begin
						for (int i = 0; i < n_rows; i++) begin
							for (int j = 0; j < n_cols; j++) begin
								acc = 0;
								for (int k = 0; k < n_inner; k++)
									acc += longint'(a_entries[i*MAX_DIM + k]) *
										longint'(b_entries[k*MAX_DIM + j]);
								p.row = POS_W'(i);
								p.column = POS_W'(j);
								p.value = acc[PROD_W-1:0];
								p.last = (i == n_rows - 1) && (j == n_cols - 1);
								p.size_error = 1'b0;
								pending_products.push_back(p);
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_product(product_t got);
			product_t want;
			if (pending_products.size() == 0) begin
				$error("unexpected result: row %0d column %0d value %0d", got.row, got.column,
					got.value);
				mismatches++;
				return;
			end
			want = pending_products.pop_front();
			if (got.row !== want.row) begin
				$error("product_row: expected %0d, actual %0d", want.row, got.row);
				mismatches++;
			end
			if (got.column !== want.column) begin
				$error("product_column: expected %0d, actual %0d", want.column, got.column);
				mismatches++;
			end
			if (got.value !== want.value) begin
				$error("product_value: expected %0d, actual %0d", want.value, got.value);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last_entry: expected %0d, actual %0d", want.last, got.last);
				mismatches++;
			end
			if (got.size_error !== want.size_error) begin
				$error("size_error: expected %0d, actual %0d", want.size_error, got.size_error);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_products.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mm_item_if   item_ch ();
	mm_result_if result_ch ();
	mm_cfg_if    cfg_ch ();

	matrix_multiply DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	product_scoreboard sb = new();

	bit [MAX_DIM*MAX_DIM-1:0] a_written;
	bit [MAX_DIM*MAX_DIM-1:0] b_written;
	int request_count = 0;
	int rx_hold_cycles = 0;
	bit no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_dim();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(1, 3);
		if (r < 9)
			return $urandom_range(4, 7);
		return MAX_DIM;
	endfunction

	function automatic logic signed [VALUE_BITS-1:0] pick_value(int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == 1 || r < 7)
			return {1'b1, {(VALUE_BITS-1){1'b0}}};
		if (r < 15)
			return {1'b0, {(VALUE_BITS-1){1'b1}}};
		return VALUE_BITS'($urandom);
	endfunction

	initial begin : receiver
		int       stall;
		product_t got;
		stall = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got.row = result_ch.product_row;
				got.column = result_ch.product_column;
				got.value = result_ch.product_value;
				got.last = result_ch.last_entry;
				got.size_error = result_ch.size_error;
				sb.check_product(got);
			end
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] row,
		logic [POS_W-1:0] col, logic signed [VALUE_BITS-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= func;
		item_ch.entry_row <= row;
		item_ch.entry_column <= col;
		item_ch.entry_value <= value;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		sb.note_request(func, row, col, value);
		if (func == FUNC_WRITE_A)
			a_written[row*MAX_DIM + col] = 1'b1;
		if (func == FUNC_WRITE_B)
			b_written[row*MAX_DIM + col] = 1'b1;
		if (func != FUNC_UNUSED)
			request_count++;
	endtask

	task automatic wait_results();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sb.note_dim(idx, data);
	endtask

	task automatic configure(logic [DIM_W-1:0] ra, logic [DIM_W-1:0] rc,
		logic [DIM_W-1:0] rb, logic [DIM_W-1:0] rbc);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_dim(CFG_A_ROWS, ra);
		write_dim(CFG_A_COLUMNS, rc);
		write_dim(CFG_B_ROWS, rb);
		write_dim(CFG_B_COLUMNS, rbc);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic load_operands(int mode, bit rewrite_all);
		int ar;
		int ac;
		int bc;
		ar = sb.dim(CFG_A_ROWS);
		ac = sb.dim(CFG_A_COLUMNS);
		bc = sb.dim(CFG_B_COLUMNS);
		if (sb.sizes_agree()) begin
			for (int i = 0; i < ar; i++)
				for (int k = 0; k < ac; k++)
					if (rewrite_all || !a_written[i*MAX_DIM + k])
						send_request(FUNC_WRITE_A, POS_W'(i), POS_W'(k), pick_value(mode));
			for (int k = 0; k < ac; k++)
				for (int j = 0; j < bc; j++)
					if (rewrite_all || !b_written[k*MAX_DIM + j])
						send_request(FUNC_WRITE_B, POS_W'(k), POS_W'(j), pick_value(mode));
		end
	endtask

	task automatic compute_product();
		send_request(FUNC_COMPUTE, POS_W'($urandom), POS_W'($urandom), VALUE_BITS'($urandom));
	endtask

	task automatic scatter_writes(int count, int mode);
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				send_request(FUNC_UNUSED, POS_W'($urandom), POS_W'($urandom),
					VALUE_BITS'($urandom));
			else
				send_request((r < 55) ? FUNC_WRITE_A : FUNC_WRITE_B, POS_W'($urandom),
					POS_W'($urandom), pick_value(mode));
		end
	endtask

	task automatic random_phase(bit full_size);
		int ar;
		int ac;
		int bc;
		int pick;
		int mode;
		logic [DIM_W-1:0] ra;
		logic [DIM_W-1:0] rc;
		logic [DIM_W-1:0] rb;
		logic [DIM_W-1:0] rbc;
		no_idle = ($urandom_range(0, 3) == 0);
		mode = full_size ? 1 : 0;
		if (full_size) begin
			ra = DIM_W'(MAX_DIM);
			rc = DIM_W'(MAX_DIM);
			rb = DIM_W'(MAX_DIM);
			rbc = DIM_W'(MAX_DIM);
		end else begin
			ar = pick_dim();
			ac = pick_dim();
			bc = pick_dim();
			ra = DIM_W'(ar);
			rc = DIM_W'(ac);
			rb = DIM_W'(ac);
			rbc = DIM_W'(bc);
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				case ($urandom_range(0, 3))
					0: ra = '0;
					1: rc = '0;
					2: rb = '0;
					default: rbc = '0;
				endcase
			end else if (pick < 16) begin
				rb = DIM_W'(ac % MAX_DIM + 1);
			end else if (pick < 26) begin
				rc = DIM_W'($urandom_range(MAX_DIM, 15));
				rb = DIM_W'($urandom_range(MAX_DIM, 15));
				if ($urandom_range(0, 1) == 0)
					ra = DIM_W'($urandom_range(MAX_DIM, 15));
				if ($urandom_range(0, 1) == 0)
					rbc = DIM_W'($urandom_range(MAX_DIM, 15));
			end
		end
		configure(ra, rc, rb, rbc);
		load_operands(mode, full_size);
		compute_product();
		if (full_size) begin
			// The receiver stalls while new requests keep coming, so the input backs up.
			rx_hold_cycles = 300;
			scatter_writes(12, mode);
			load_operands(mode, 1'b0);
			compute_product();
		end
		repeat ($urandom_range(0, 2)) begin
			scatter_writes($urandom_range(0, 6), mode);
			if ($urandom_range(0, 4) == 0)
				wait_results();
			load_operands(mode, 1'b0);
			compute_product();
		end
	endtask

	initial begin : stimulus
		a_written = '0;
		b_written = '0;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.func <= FUNC_WRITE_A;
		item_ch.entry_row <= '0;
		item_ch.entry_column <= '0;
		item_ch.entry_value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_A_ROWS;
		cfg_ch.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		configure(4'd1, 4'd1, 4'd1, 4'd1);
		send_request(FUNC_WRITE_A, 3'd0, 3'd0, -16'sd32768);
		send_request(FUNC_WRITE_B, 3'd0, 3'd0, -16'sd32768);
		compute_product();
		send_request(FUNC_UNUSED, 3'd7, 3'd7, -16'sd1);
		send_request(FUNC_WRITE_A, 3'd0, 3'd0, 16'sd32767);
		compute_product();
		send_request(FUNC_WRITE_A, 3'd7, 3'd7, 16'sh5555);
		send_request(FUNC_WRITE_B, 3'd7, 3'd7, 16'shAAAA);
		send_request(FUNC_WRITE_B, 3'd0, 3'd0, 16'sd32767);
		compute_product();
		configure(4'd2, 4'd1, 4'd2, 4'd1);
		compute_product();
		configure(4'd0, 4'd8, 4'd8, 4'd8);
		compute_product();
		configure(4'd3, 4'd0, 4'd0, 4'd3);
		compute_product();
		configure(4'd1, 4'd1, 4'd1, 4'd0);
		compute_product();

		random_phase(1'b1);
		while (request_count < REQUEST_TARGET)
			random_phase(1'b0);

		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
